// File: sv/plc_pkg.sv
// Package for the password lock controller.
// Holds field widths, command, message and motor codes, register indexes and reset values.
// No dependencies.
package plc_pkg;

  // Field widths
  localparam int OPCODE_W   = 3;
  localparam int KEY_W      = 8;
  localparam int MSG_W      = 2;
  localparam int MOTOR_W    = 2;
  localparam int ATTEMPT_W  = 4;
  localparam int TICK_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Command codes
  localparam logic [OPCODE_W-1:0] OP_SETUP  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_OPEN   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_CHANGE = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_BYTE   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_TICK   = 3'd4;

  // Status message codes
  localparam logic [MSG_W-1:0] MSG_OK   = 2'd0;
  localparam logic [MSG_W-1:0] MSG_FAIL = 2'd1;
  localparam logic [MSG_W-1:0] MSG_DONE = 2'd2;

  // Motor drive codes
  localparam logic [MOTOR_W-1:0] MOTOR_STOP = 2'd0;
  localparam logic [MOTOR_W-1:0] MOTOR_CW   = 2'd1;
  localparam logic [MOTOR_W-1:0] MOTOR_ACW  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DOOR_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 2'd2;

  // Configuration reset values
  localparam logic [TICK_W-1:0]    DOOR_TICKS_RST   = 8'd15;
  localparam logic [TICK_W-1:0]    ALARM_TICKS_RST  = 8'd60;
  localparam logic [ATTEMPT_W-1:0] MAX_ATTEMPTS_RST = 4'd3;

  // Saturation limits of the counters
  localparam logic [TICK_W-1:0]    TICK_MAX    = 8'd255;
  localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX = 4'd15;

endpackage

// File: sv/plc_cmd_if.sv
// Command channel of the password lock controller: valid/ready plus command payload.
// Depends on plc_pkg for field widths.
interface plc_cmd_if
  import plc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [KEY_W-1:0]    key_byte;
  logic                pir_present;

  modport source (output valid, output opcode, output key_byte, output pir_present,
                  input ready);
  modport sink   (input valid, input opcode, input key_byte, input pir_present,
                  output ready);
endinterface

// File: sv/plc_status_if.sv
// Status channel of the password lock controller: valid/ready plus result payload.
// Depends on plc_pkg for field widths.
interface plc_status_if
  import plc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 message_valid;
  logic [MSG_W-1:0]     message;
  logic [MOTOR_W-1:0]   motor_drive;
  logic                 alarm_buzzer;
  logic [ATTEMPT_W-1:0] attempts_seen;

  modport source (output valid, output message_valid, output message, output motor_drive,
                  output alarm_buzzer, output attempts_seen, input ready);
  modport sink   (input valid, input message_valid, input message, input motor_drive,
                  input alarm_buzzer, input attempts_seen, output ready);
endinterface

// File: sv/password_lock_controller.sv
// Digital combination lock controller. Each command transaction (start setup, start
// open, start change, one password byte, or one timer tick with the motion-sensor
// level) updates the lock state in the cycle it is accepted and produces exactly one
// status transaction, held in an output register. Throughput is one transaction per
// clock: the whole update is a single compare/count step against registered state,
// and the command side stays ready while the output register is empty or being
// drained in the same cycle. Each status is presented in the cycle after its command
// is accepted. The stored password is cleared by reset; configuration writes are
// taken at any time but are meant for idle periods.
// Depends on plc_pkg, plc_cmd_if and plc_status_if.
module password_lock_controller
  import plc_pkg::*;
#(
  parameter int PASSWORD_LENGTH = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  plc_cmd_if.sink               cmd,
  plc_status_if.source          status
);

  localparam int IDX_W = (PASSWORD_LENGTH > 1) ? $clog2(PASSWORD_LENGTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PASSWORD_LENGTH - 1);

  typedef enum logic [3:0] {
    PH_IDLE, PH_SETUP_A, PH_SETUP_B, PH_OPEN, PH_CHANGE,
    PH_CW, PH_SENSE, PH_WAIT_CLEAR, PH_ACW, PH_ALARM
  } phase_t;

  // Configuration registers
  logic [TICK_W-1:0]    door_ticks;
  logic [TICK_W-1:0]    alarm_ticks;
  logic [ATTEMPT_W-1:0] max_attempts;

  // Lock state
  phase_t               phase, phase_next;
  logic [IDX_W-1:0]     byte_index, byte_index_next;
  logic                 mismatch_seen, mismatch_seen_next;
  logic [ATTEMPT_W-1:0] failed_attempts, failed_attempts_next;
  logic [TICK_W-1:0]    tick_count, tick_count_next;
  logic [KEY_W-1:0]     first_entry     [PASSWORD_LENGTH];
  logic [KEY_W-1:0]     stored_password [PASSWORD_LENGTH];

  // Step results
  logic                 take;
  logic                 msg_v;
  logic [MSG_W-1:0]     msg_c;
  logic                 entry_we;
  logic                 copy_password;
  logic                 entry_phase;
  logic                 last_byte;
  logic                 byte_mismatch;
  logic                 mismatch_acc;
  logic [TICK_W-1:0]    tick_inc;
  logic [TICK_W-1:0]    tick_limit;
  logic                 tick_done;
  logic [ATTEMPT_W-1:0] fail_inc;
  logic [MOTOR_W-1:0]   motor_next;

  // Accept a command whenever the output register can take its result
  assign cmd.ready = !status.valid || status.ready;
  assign take      = cmd.valid && cmd.ready;

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      door_ticks   <= DOOR_TICKS_RST;
      alarm_ticks  <= ALARM_TICKS_RST;
      max_attempts <= MAX_ATTEMPTS_RST;
    end else if (wr_en) begin
      if (wr_index == REG_DOOR_TICKS)   door_ticks   <= wr_data;
      if (wr_index == REG_ALARM_TICKS)  alarm_ticks  <= wr_data;
      if (wr_index == REG_MAX_ATTEMPTS) max_attempts <= wr_data[ATTEMPT_W-1:0];
    end
  end

  // Shared compare and count terms
  assign entry_phase = (phase == PH_SETUP_A) || (phase == PH_SETUP_B) ||
                       (phase == PH_OPEN) || (phase == PH_CHANGE);
  assign last_byte   = (byte_index == LAST_IDX);
  assign byte_mismatch = (phase == PH_SETUP_B) ? (first_entry[byte_index] != cmd.key_byte)
                                               : (stored_password[byte_index] != cmd.key_byte);
  assign mismatch_acc = mismatch_seen || ((phase != PH_SETUP_A) && byte_mismatch);
  assign tick_inc   = (tick_count == TICK_MAX) ? TICK_MAX : tick_count + 1'b1;
  assign tick_limit = (phase == PH_ALARM) ? alarm_ticks : door_ticks;
  assign tick_done  = (tick_inc >= tick_limit);
  assign fail_inc   = (failed_attempts == ATTEMPT_MAX) ? ATTEMPT_MAX : failed_attempts + 1'b1;

  // Next state and message for one command
  always_comb begin
    phase_next           = phase;
    byte_index_next      = byte_index;
    mismatch_seen_next   = mismatch_seen;
    failed_attempts_next = failed_attempts;
    tick_count_next      = tick_count;
    msg_v                = 1'b0;
    msg_c                = MSG_OK;
    entry_we             = 1'b0;
    copy_password        = 1'b0;

    if (cmd.opcode == OP_SETUP || cmd.opcode == OP_OPEN || cmd.opcode == OP_CHANGE) begin
      // Start an entry only from idle
      if (phase == PH_IDLE) begin
        byte_index_next    = '0;
        mismatch_seen_next = 1'b0;
        if (cmd.opcode == OP_SETUP)     phase_next = PH_SETUP_A;
        else if (cmd.opcode == OP_OPEN) phase_next = PH_OPEN;
        else                            phase_next = PH_CHANGE;
      end
    end else if (cmd.opcode == OP_BYTE) begin
      if (entry_phase) begin
        entry_we           = (phase == PH_SETUP_A);
        mismatch_seen_next = mismatch_acc;
        byte_index_next    = last_byte ? '0 : byte_index + 1'b1;
        if (last_byte) begin
          // Close the entry
          priority case (phase)
            PH_SETUP_A: begin
              phase_next         = PH_SETUP_B;
              mismatch_seen_next = 1'b0;
            end
            PH_SETUP_B: begin
              msg_v              = 1'b1;
              mismatch_seen_next = 1'b0;
              if (mismatch_acc) begin
                msg_c      = MSG_FAIL;
                phase_next = PH_SETUP_A;
              end else begin
                msg_c         = MSG_OK;
                copy_password = 1'b1;
                phase_next    = PH_IDLE;
              end
            end
            default: begin
              // Open or change
              msg_v = 1'b1;
              if (mismatch_acc) begin
                msg_c                = MSG_FAIL;
                failed_attempts_next = fail_inc;
                if (fail_inc >= max_attempts) begin
                  phase_next      = PH_ALARM;
                  tick_count_next = '0;
                end else begin
                  phase_next = PH_IDLE;
                end
              end else begin
                msg_c                = MSG_OK;
                failed_attempts_next = '0;
                if (phase == PH_OPEN) begin
                  phase_next      = PH_CW;
                  tick_count_next = '0;
                end else begin
                  phase_next         = PH_SETUP_A;
                  mismatch_seen_next = 1'b0;
                end
              end
            end
          endcase
        end
      end
    end else if (cmd.opcode == OP_TICK) begin
      unique case (phase)
        PH_CW: begin
          tick_count_next = tick_done ? '0 : tick_inc;
          if (tick_done) phase_next = PH_SENSE;
        end
        PH_SENSE: begin
          msg_v = 1'b1;
          if (cmd.pir_present) begin
            msg_c      = MSG_OK;
            phase_next = PH_WAIT_CLEAR;
          end else begin
            msg_c           = MSG_FAIL;
            phase_next      = PH_ACW;
            tick_count_next = '0;
          end
        end
        PH_WAIT_CLEAR: begin
          if (!cmd.pir_present) begin
            msg_v           = 1'b1;
            msg_c           = MSG_DONE;
            phase_next      = PH_ACW;
            tick_count_next = '0;
          end
        end
        PH_ACW: begin
          tick_count_next = tick_done ? '0 : tick_inc;
          if (tick_done) phase_next = PH_IDLE;
        end
        PH_ALARM: begin
          tick_count_next = tick_done ? '0 : tick_inc;
          if (tick_done) begin
            failed_attempts_next = '0;
            phase_next           = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // Motor level after the step
  always_comb begin
    unique case (phase_next)
      PH_CW:   motor_next = MOTOR_CW;
      PH_ACW:  motor_next = MOTOR_ACW;
      default: motor_next = MOTOR_STOP;
    endcase
  end

  // Advance control state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      byte_index      <= '0;
      mismatch_seen   <= 1'b0;
      failed_attempts <= '0;
      tick_count      <= '0;
    end else if (take) begin
      phase           <= phase_next;
      byte_index      <= byte_index_next;
      mismatch_seen   <= mismatch_seen_next;
      failed_attempts <= failed_attempts_next;
      tick_count      <= tick_count_next;
    end
  end

  // Hold the first setup entry
  always_ff @(posedge clk) begin
    if (take && entry_we) begin
      first_entry[byte_index] <= cmd.key_byte;
    end
  end

  // Store the password once both setup entries agree
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PASSWORD_LENGTH; i++) stored_password[i] <= '0;
    end else if (take && copy_password) begin
      for (int i = 0; i < PASSWORD_LENGTH; i++) stored_password[i] <= first_entry[i];
    end
  end

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      status.valid <= 1'b0;
    end else if (take) begin
      status.valid <= 1'b1;
    end else if (status.ready) begin
      status.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status.message_valid <= msg_v;
      status.message       <= msg_c;
      status.motor_drive   <= motor_next;
      status.alarm_buzzer  <= (phase_next == PH_ALARM);
      status.attempts_seen <= failed_attempts_next;
    end
  end

endmodule

// File: tb/tb_password_lock_controller.sv
// Self-checking testbench for password_lock_controller: drives command transactions,
// predicts every status transaction with its own lock model and compares field by field.
// Depends on plc_pkg, plc_cmd_if, plc_status_if and the password_lock_controller RTL.
module tb_password_lock_controller;
  import plc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD       = 10;
  localparam int RESET_CYCLES     = 8;
  localparam int CODE_LEN         = 5;
  localparam int CYCLE_LIMIT      = 100000;
  localparam int SETTLE_CYCLES    = 4;
  localparam int CONFIRM_MISS_PCT = 25;

  // Opcodes the block has no use for
  localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENTER_FIRST,
    ST_ENTER_CONFIRM,
    ST_ENTER_OPEN,
    ST_ENTER_OLD,
    ST_DOOR_OPENING,
    ST_SENSE,
    ST_WAIT_CLEAR,
    ST_DOOR_CLOSING,
    ST_ALARM
  } lock_phase_t;

  typedef struct packed {
    lock_phase_t          phase;
    logic [3:0]           pos;
    logic [15:0][KEY_W-1:0] first_code;
    logic [15:0][KEY_W-1:0] saved_code;
    logic                 mismatch;
    logic [ATTEMPT_W-1:0] fails;
    logic [TICK_W-1:0]    ticks;
    logic [TICK_W-1:0]    door_limit;
    logic [TICK_W-1:0]    alarm_limit;
    logic [ATTEMPT_W-1:0] fail_limit;
  } lock_model_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [KEY_W-1:0]    key;
    logic                pir;
  } lock_cmd_t;

  typedef struct packed {
    logic                 msg_valid;
    logic [MSG_W-1:0]     msg;
    logic [MOTOR_W-1:0]   motor;
    logic                 buzzer;
    logic [ATTEMPT_W-1:0] fails;
  } lock_status_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  plc_cmd_if    cmd_ch();
  plc_status_if status_ch();

  password_lock_controller #(.PASSWORD_LENGTH(CODE_LEN)) DUT (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cmd      (cmd_ch),
    .status   (status_ch)
  );

  lock_cmd_t    pending_cmds[$];
  lock_status_t expected_status[$];
  lock_model_t  plan_state;
  lock_model_t  check_state;
  logic         cmd_taken;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           noise_pct      = 8;
  int           bad_pct        = 20;
  int           wrong_slot     = -1;
  int           effective_cmds = 0;
  int           error_count    = 0;
  int           cycle_count    = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic lock_model_t lock_reset_state();
    lock_model_t m;
    m             = '0;
    m.phase       = ST_IDLE;
    m.door_limit  = DOOR_TICKS_RST;
    m.alarm_limit = ALARM_TICKS_RST;
    m.fail_limit  = MAX_ATTEMPTS_RST;
    return m;
  endfunction

  function automatic void apply_reg(ref lock_model_t m, input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_DOOR_TICKS:   m.door_limit  = val;
      REG_ALARM_TICKS:  m.alarm_limit = val;
      REG_MAX_ATTEMPTS: m.fail_limit  = val[ATTEMPT_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the lock by one command and return the status it produces
  function automatic lock_status_t lock_advance(ref lock_model_t m, input lock_cmd_t c);
    lock_status_t       r;
    logic [3:0]         idx;
    logic               last;
    logic [TICK_W-1:0]  lim;
    r = '0;
    case (c.opcode)
      OP_SETUP, OP_OPEN, OP_CHANGE: begin
        if (m.phase == ST_IDLE) begin
          if (c.opcode == OP_SETUP) m.phase = ST_ENTER_FIRST;
          else if (c.opcode == OP_OPEN) m.phase = ST_ENTER_OPEN;
          else m.phase = ST_ENTER_OLD;
          m.pos      = '0;
          m.mismatch = 1'b0;
        end
      end
      OP_BYTE: begin
        if (m.phase inside {ST_ENTER_FIRST, ST_ENTER_CONFIRM, ST_ENTER_OPEN, ST_ENTER_OLD}) begin
          idx  = m.pos;
          last = (int'(idx) + 1 >= CODE_LEN);
          if (m.phase == ST_ENTER_FIRST) m.first_code[idx] = c.key;
          else if (m.phase == ST_ENTER_CONFIRM) begin
            if (m.first_code[idx] != c.key) m.mismatch = 1'b1;
          end else if (m.saved_code[idx] != c.key) m.mismatch = 1'b1;
          m.pos = idx + 4'd1;
          if (last) begin
            case (m.phase)
              ST_ENTER_FIRST: begin
                m.phase    = ST_ENTER_CONFIRM;
                m.pos      = '0;
                m.mismatch = 1'b0;
              end
              ST_ENTER_CONFIRM: begin
                r.msg_valid = 1'b1;
                if (m.mismatch) begin
                  r.msg   = MSG_FAIL;
                  m.phase = ST_ENTER_FIRST;
                end else begin
                  r.msg        = MSG_OK;
                  m.saved_code = m.first_code;
                  m.phase      = ST_IDLE;
                end
                m.pos      = '0;
                m.mismatch = 1'b0;
              end
              default: begin
                // open or change: both count failures toward the alarm
                r.msg_valid = 1'b1;
                if (m.mismatch) begin
                  r.msg = MSG_FAIL;
                  if (m.fails != ATTEMPT_MAX) m.fails = m.fails + 1'b1;
                  if (m.fails >= m.fail_limit) begin
                    m.phase = ST_ALARM;
                    m.ticks = '0;
                  end else m.phase = ST_IDLE;
                end else begin
                  r.msg   = MSG_OK;
                  m.fails = '0;
                  if (m.phase == ST_ENTER_OPEN) begin
                    m.phase = ST_DOOR_OPENING;
                    m.ticks = '0;
                  end else begin
                    m.phase    = ST_ENTER_FIRST;
                    m.pos      = '0;
                    m.mismatch = 1'b0;
                  end
                end
              end
            endcase
          end
        end
      end
      OP_TICK: begin
        case (m.phase)
          ST_DOOR_OPENING, ST_DOOR_CLOSING, ST_ALARM: begin
            if (m.ticks != TICK_MAX) m.ticks = m.ticks + 1'b1;
            lim = (m.phase == ST_ALARM) ? m.alarm_limit : m.door_limit;
            if (m.ticks >= lim) begin
              m.ticks = '0;
              if (m.phase == ST_DOOR_OPENING) m.phase = ST_SENSE;
              else begin
                if (m.phase == ST_ALARM) m.fails = '0;
                m.phase = ST_IDLE;
              end
            end
          end
          ST_SENSE: begin
            r.msg_valid = 1'b1;
            if (c.pir) begin
              r.msg   = MSG_OK;
              m.phase = ST_WAIT_CLEAR;
            end else begin
              r.msg   = MSG_FAIL;
              m.phase = ST_DOOR_CLOSING;
              m.ticks = '0;
            end
          end
          ST_WAIT_CLEAR: begin
            if (!c.pir) begin
              r.msg_valid = 1'b1;
              r.msg       = MSG_DONE;
              m.phase     = ST_DOOR_CLOSING;
              m.ticks     = '0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (m.phase == ST_DOOR_OPENING) r.motor = MOTOR_CW;
    else if (m.phase == ST_DOOR_CLOSING) r.motor = MOTOR_ACW;
    else r.motor = MOTOR_STOP;
    r.buzzer = (m.phase == ST_ALARM);
    r.fails  = m.fails;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Queue one command and step the planning copy so later picks stay well formed
  task automatic queue_cmd(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic pir);
    lock_cmd_t    c;
    lock_model_t  prior;
    lock_status_t r;
    c     = '{opcode: op, key: key, pir: pir};
    prior = plan_state;
    r     = lock_advance(plan_state, c);
    pending_cmds.push_back(c);
    if (prior != plan_state || r.msg_valid) effective_cmds++;
  endtask

  // Pick the next command from where the lock will be: mostly well formed, some noise
  task automatic queue_random_cmd();
    logic [OPCODE_W-1:0] op;
    logic [KEY_W-1:0]    key;
    logic                pir;
    int                  pick;
    int                  miss;
    op  = OP_TICK;
    key = KEY_W'($urandom);
    pir = 1'($urandom);
    if ($urandom_range(99) < noise_pct) op = OPCODE_W'($urandom);
    else begin
      case (plan_state.phase)
        ST_IDLE: begin
          pick = $urandom_range(9);
          if (pick < 6) op = OP_OPEN;
          else if (pick < 8) op = OP_CHANGE;
          else op = OP_SETUP;
        end
        ST_ENTER_FIRST: begin
          op = OP_BYTE;
          if ($urandom_range(4) == 0) key = {KEY_W{key[0]}};
        end
        ST_ENTER_CONFIRM, ST_ENTER_OPEN, ST_ENTER_OLD: begin
          op = OP_BYTE;
          if (plan_state.pos == 0) begin
            miss = (plan_state.phase == ST_ENTER_CONFIRM) ? CONFIRM_MISS_PCT : bad_pct;
            wrong_slot = ($urandom_range(99) < miss) ? int'($urandom_range(CODE_LEN - 1))
                                                     : -1;
          end
          key = (plan_state.phase == ST_ENTER_CONFIRM) ? plan_state.first_code[plan_state.pos]
                                                        : plan_state.saved_code[plan_state.pos];
          if (wrong_slot == int'(plan_state.pos)) key = key ^ (8'd1 << $urandom_range(7));
        end
        ST_WAIT_CLEAR: pir = ($urandom_range(99) < 70);
        default: ;
      endcase
    end
    queue_cmd(op, key, pir);
  endtask

  task automatic run_cmds(input int n);
    int goal;
    goal = effective_cmds + n;
    while (effective_cmds < goal) queue_random_cmd();
  endtask

  // Hold until every queued command is taken and every status has come back
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || cmd_ch.valid || expected_status.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(negedge clk);
    wr_en    <= 1'b0;
    apply_reg(plan_state, idx, val);
  endtask

  task automatic write_all(input logic [TICK_W-1:0] door, input logic [TICK_W-1:0] alarm,
                           input logic [ATTEMPT_W-1:0] tries);
    write_reg(REG_DOOR_TICKS, door);
    write_reg(REG_ALARM_TICKS, alarm);
    write_reg(REG_MAX_ATTEMPTS, CFG_DATA_W'(tries));
  endtask

  // Command driver: present the next transaction once the previous one is taken
  always @(negedge clk) begin : cmd_driver
    lock_cmd_t nxt;
    if (rst) begin
      cmd_ch.valid    <= 1'b0;
      status_ch.ready <= 1'b0;
    end else begin
      if (!cmd_ch.valid || cmd_taken) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_cmds.pop_front();
          cmd_ch.valid       <= 1'b1;
          cmd_ch.opcode      <= nxt.opcode;
          cmd_ch.key_byte    <= nxt.key;
          cmd_ch.pir_present <= nxt.pir;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
      status_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on each accepted command, check each accepted status
  always @(posedge clk) begin : status_monitor
    lock_status_t got;
    lock_status_t want;
    if (rst) begin
      cmd_taken   <= 1'b0;
      check_state = lock_reset_state();
    end else begin
      cmd_taken <= cmd_ch.valid && cmd_ch.ready;
      if (wr_en) apply_reg(check_state, wr_index, wr_data);
      if (status_ch.valid && status_ch.ready) begin
        got = '{msg_valid: status_ch.message_valid, msg: status_ch.message,
                motor: status_ch.motor_drive, buzzer: status_ch.alarm_buzzer,
                fails: status_ch.attempts_seen};
        if (expected_status.size() == 0) begin
          report_mismatch("status with nothing pending", 1, 0);
        end else begin
          want = expected_status.pop_front();
          if (got.msg_valid !== want.msg_valid)
            report_mismatch("message_valid", int'(got.msg_valid), int'(want.msg_valid));
          if (got.msg !== want.msg)
            report_mismatch("message", int'(got.msg), int'(want.msg));
          if (got.motor !== want.motor)
            report_mismatch("motor_drive", int'(got.motor), int'(want.motor));
          if (got.buzzer !== want.buzzer)
            report_mismatch("alarm_buzzer", int'(got.buzzer), int'(want.buzzer));
          if (got.fails !== want.fails)
            report_mismatch("attempts_seen", int'(got.fails), int'(want.fails));
        end
      end
      if (cmd_ch.valid && cmd_ch.ready)
        expected_status.push_back(lock_advance(check_state,
            '{opcode: cmd_ch.opcode, key: cmd_ch.key_byte, pir: cmd_ch.pir_present}));
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d status transactions outstanding",
             cycle_count, expected_status.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst                = 1'b1;
    wr_en              = 1'b0;
    wr_index           = '0;
    wr_data            = '0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.opcode      = '0;
    cmd_ch.key_byte    = '0;
    cmd_ch.pir_present = 1'b0;
    status_ch.ready    = 1'b0;
    plan_state         = lock_reset_state();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: stray inputs, unused opcodes, open against the cleared password,
    // busy commands while the door moves
    queue_cmd(OP_TICK, 8'h00, 1'b1);
    queue_cmd(OP_BYTE, 8'hFF, 1'b0);
    queue_cmd(OP_UNUSED_LO, 8'hFF, 1'b1);
    queue_cmd(OP_UNUSED_HI, 8'h00, 1'b0);
    queue_cmd(OP_OPEN, 8'h00, 1'b0);
    repeat (CODE_LEN) queue_cmd(OP_BYTE, 8'h00, 1'b0);
    queue_cmd(OP_SETUP, 8'h00, 1'b0);
    queue_cmd(OP_CHANGE, 8'h00, 1'b0);
    queue_cmd(OP_OPEN, 8'h00, 1'b0);
    queue_cmd(OP_BYTE, 8'hA5, 1'b1);
    queue_cmd(OP_TICK, 8'h00, 1'b0);

    // Reset register values, no idling
    run_cmds(80);
    wait_quiet();

    // Shortest timers and a single allowed failure; sender mostly idle, with a full pause
    write_all(8'd1, 8'd1, 4'd1);
    send_idle_pct = 87;
    run_cmds(60);
    wait_quiet();
    run_cmds(60);
    wait_quiet();

    // Mid-range settings; receiver mostly stalling
    write_all(TICK_W'($urandom_range(2, 6)), TICK_W'($urandom_range(2, 6)),
              ATTEMPT_W'($urandom_range(2, 4)));
    send_idle_pct  = 0;
    recv_stall_pct = 87;
    run_cmds(150);
    wait_quiet();

    // Longest timers and most attempts: fail up to the alarm, then open the door
    write_all(TICK_MAX, TICK_MAX, ATTEMPT_MAX);
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    noise_pct      = 0;
    bad_pct        = 100;
    for (int k = 0; k < 2000 && plan_state.fails != ATTEMPT_MAX; k++) queue_random_cmd();
    noise_pct = 8;
    bad_pct   = 0;
    run_cmds(500);
    wait_quiet();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/plc_pkg.sv
sv/plc_cmd_if.sv
sv/plc_status_if.sv
sv/password_lock_controller.sv
tb/tb_password_lock_controller.sv
